// ----- rtl/ack_retransmit_tracker_core_macros.svh -----
// assertion macros for the ack retransmit tracker checker
`ifndef ACK_RETRANSMIT_TRACKER_CORE_MACROS_SVH
`define ACK_RETRANSMIT_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define ART_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ART_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/art_pkg.sv -----
// shared constants and codes of the ack retransmit tracker
`timescale 1ns / 1ps
package art_pkg;
  localparam int PENDING_SLOTS = 32;
  localparam int NODE_COUNT    = 256;
  localparam int SLOT_IW  = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int SLOT_CW  = $clog2(PENDING_SLOTS + 1);
  localparam int NODE_IW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SLOT_W   = 36;

  localparam logic [1:0] REQ_SEND  = 2'd0;
  localparam logic [1:0] REQ_FRAME = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_HB   = 2'd2;

  localparam logic [3:0] EV_QUEUED     = 4'd0;
  localparam logic [3:0] EV_ACK_OUT    = 4'd1;
  localparam logic [3:0] EV_DELIVER    = 4'd2;
  localparam logic [3:0] EV_ACKED_OK   = 4'd3;
  localparam logic [3:0] EV_RETRANSMIT = 4'd4;
  localparam logic [3:0] EV_FAILED     = 4'd5;
  localparam logic [3:0] EV_DROPPED    = 4'd6;
  localparam logic [3:0] EV_REJECTED   = 4'd7;
  localparam logic [3:0] EV_TICK_DONE  = 4'd8;

  localparam logic [1:0] CFG_OWN_NODE  = 2'd0;
  localparam logic [1:0] CFG_BCAST     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd2;
  localparam logic [1:0] CFG_RETRY     = 2'd3;

  typedef struct packed {
    logic [7:0]  seq;
    logic [7:0]  dest;
    logic [3:0]  retries;
    logic [15:0] age;
  } slot_t;
endpackage

// ----- rtl/art_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/ack_retransmit_tracker_core.sv -----
// top level of the ack retransmit tracker
// Usage:
// - input channel (in_valid/in_ready) takes one word: a send request, a
//   received frame or a tick; in_ready is high only while no item is in work
// - output channel (out_valid/out_ready) gives result words, last marks
//   the final one of an item; one result register sits on the output
// - configuration channel (cfg_valid/cfg_ready) is always ready; write only
//   while idle
// Paths, from accept to the next accept:
// - send: broadcast and table full are answered from dispatch, else the pending
//   table is scanned for the new sequence before it is queued in a free slot
// - frame: dropped at the filter, or data and heartbeat pass a duplicate check,
//   unicast data giving a second result; ack frames scan up to an early match
// - tick: the scan runs over every pending slot; the scan over the slot ram reads
//   each slot in turn and checks each pending slot in a further state
// Reset: synchronous, clears the pending and seen flags, next sequence 1,
//   registers to defaults; no clearing pass is needed
// Stall: a held result stops the sequencer in place until it is taken
`timescale 1ns / 1ps
module ack_retransmit_tracker_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [7:0] dest_node,
  input  logic [7:0] source_node,
  input  logic [7:0] frame_seq,
  input  logic [1:0] frame_kind,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] event_res,
  output logic [7:0] out_seq,
  output logic [7:0] out_node,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_DISPATCH, ST_FR_CHK, ST_SC_RD, ST_SC_CHK, ST_SC_END, ST_EMIT2
  } state_t;
  typedef enum logic [1:0] {MODE_SEND, MODE_ACK, MODE_TICK} mode_t;

  state_t state;
  mode_t  mode;

  logic [7:0]  own_node, broadcast_node;
  logic [15:0] timeout_ticks;
  logic [3:0]  retry_limit;
  logic [7:0]  next_seq;
  logic [art_pkg::PENDING_SLOTS-1:0] slot_valid;
  logic [art_pkg::NODE_COUNT-1:0]    seen_source;

  logic [1:0] req_r, kind_r;
  logic [7:0] dest_r, src_r, seq_r, cur_seq;
  logic [art_pkg::SLOT_CW-1:0] idx;
  logic [art_pkg::SLOT_IW-1:0] free_idx, free_found;
  logic [3:0] ev2;
  logic [7:0] seq2, node2;

  art_pkg::slot_t slot_rd, slot_wd;
  logic [art_pkg::SLOT_W-1:0] slot_rdata;
  logic s_we;
  logic [art_pkg::SLOT_IW-1:0] s_waddr;
  logic [7:0] last_rdata;
  logic n_we;

  logic out_free, want, emit, proceed;
  logic [3:0] e_ev;
  logic [7:0] e_seq, e_node;
  logic e_last;
  logic full, for_me, src_ok, dup, hit, timed, can_retry, at_end;
  logic [15:0] age_inc;
  logic [art_pkg::SLOT_IW-1:0] idx_s;
  logic [7:0] seq_inc;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign idx_s     = idx[art_pkg::SLOT_IW-1:0];
  assign at_end    = (idx == art_pkg::SLOT_CW'(art_pkg::PENDING_SLOTS));
  assign slot_rd   = art_pkg::slot_t'(slot_rdata);
  assign full      = &slot_valid;
  assign for_me    = (dest_r == own_node) || (dest_r == broadcast_node);
  assign src_ok    = (int'(src_r) < art_pkg::NODE_COUNT);
  assign dup       = src_ok && seen_source[src_r[art_pkg::NODE_IW-1:0]] &&
                     (last_rdata == seq_r);
  assign hit       = (slot_rd.seq == cur_seq);
  assign age_inc   = (slot_rd.age == 16'hFFFF) ? slot_rd.age : slot_rd.age + 16'd1;
  assign timed     = (age_inc >= timeout_ticks);
  assign can_retry = (slot_rd.retries < retry_limit);
  assign seq_inc   = (next_seq == 8'd255) ? 8'd1 : next_seq + 8'd1;

  always_comb begin
    free_found = '0;
    for (int i = art_pkg::PENDING_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = art_pkg::SLOT_IW'(i);
      end
    end
  end

  always_comb begin
    want = 1'b0;
    e_ev = art_pkg::EV_DROPPED;
    e_seq = seq_r;
    e_node = src_r;
    e_last = 1'b1;
    s_we = 1'b0;
    s_waddr = idx_s;
    slot_wd = slot_rd;
    case (state)
      ST_EMIT2: begin
        want = 1'b1;
        e_ev = ev2;
        e_seq = seq2;
        e_node = node2;
      end
      ST_DISPATCH: begin
        case (req_r)
          art_pkg::REQ_SEND: begin
            if (dest_r == broadcast_node) begin
              want = 1'b1;
              e_ev = art_pkg::EV_QUEUED;
              e_seq = next_seq;
              e_node = dest_r;
              e_last = 1'b0;
            end else if (full) begin
              want = 1'b1;
              e_ev = art_pkg::EV_REJECTED;
              e_seq = 8'd0;
              e_node = dest_r;
            end
          end
          art_pkg::REQ_FRAME: begin
            if (!for_me || (kind_r != art_pkg::KIND_ACK &&
                kind_r != art_pkg::KIND_DATA && kind_r != art_pkg::KIND_HB)) begin
              want = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_FR_CHK: begin
        if (dup) begin
          want = 1'b1;
        end else if (kind_r == art_pkg::KIND_DATA) begin
          want = 1'b1;
          if (dest_r == broadcast_node) begin
            e_ev = art_pkg::EV_DELIVER;
          end else begin
            e_ev = art_pkg::EV_ACK_OUT;
            e_last = 1'b0;
          end
        end
      end
      ST_SC_CHK: begin
        case (mode)
          MODE_SEND: begin
            if (hit) begin
              want = 1'b1;
              e_ev = art_pkg::EV_QUEUED;
              e_seq = cur_seq;
              e_node = dest_r;
            end
          end
          MODE_ACK: begin
            if (hit) begin
              want = 1'b1;
              e_ev = art_pkg::EV_ACKED_OK;
              e_node = slot_rd.dest;
            end
          end
          default: begin
            e_seq = slot_rd.seq;
            e_node = slot_rd.dest;
            slot_wd.age = age_inc;
            if (timed) begin
              want = 1'b1;
              e_last = 1'b0;
              if (can_retry) begin
                e_ev = art_pkg::EV_RETRANSMIT;
                slot_wd.retries = slot_rd.retries + 4'd1;
                slot_wd.age = 16'd0;
                s_we = 1'b1;
              end else begin
                e_ev = art_pkg::EV_FAILED;
              end
            end else begin
              s_we = 1'b1;
            end
          end
        endcase
      end
      ST_SC_END: begin
        want = 1'b1;
        case (mode)
          MODE_SEND: begin
            e_ev = art_pkg::EV_QUEUED;
            e_seq = cur_seq;
            e_node = dest_r;
            s_we = 1'b1;
            s_waddr = free_idx;
            slot_wd.seq = cur_seq;
            slot_wd.dest = dest_r;
            slot_wd.retries = 4'd0;
            slot_wd.age = 16'd0;
          end
          MODE_ACK: ;
          default: begin
            e_ev = art_pkg::EV_TICK_DONE;
            e_seq = 8'd0;
            e_node = 8'd0;
          end
        endcase
      end
      default: ;
    endcase
    proceed = !want || out_free;
    emit = want && out_free;
    s_we = s_we && proceed;
    n_we = (state == ST_FR_CHK) && !dup && src_ok && proceed;
  end

  art_ram #(.WIDTH(art_pkg::SLOT_W), .DEPTH(art_pkg::PENDING_SLOTS)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(slot_wd),
    .raddr(idx_s), .rdata(slot_rdata)
  );

  art_ram #(.WIDTH(8), .DEPTH(art_pkg::NODE_COUNT)) u_seq_ram (
    .clk(clk), .we(n_we), .waddr(src_r[art_pkg::NODE_IW-1:0]), .wdata(seq_r),
    .raddr(src_r[art_pkg::NODE_IW-1:0]), .rdata(last_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode <= MODE_SEND;
      out_valid <= 1'b0;
      own_node <= 8'd0;
      broadcast_node <= 8'd255;
      timeout_ticks <= 16'd10;
      retry_limit <= 4'd3;
      next_seq <= 8'd1;
      slot_valid <= '0;
      seen_source <= '0;
      idx <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          art_pkg::CFG_OWN_NODE: own_node <= cfg_data[7:0];
          art_pkg::CFG_BCAST:    broadcast_node <= cfg_data[7:0];
          art_pkg::CFG_TIMEOUT:  timeout_ticks <= cfg_data;
          art_pkg::CFG_RETRY:    retry_limit <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
        event_res <= e_ev;
        out_seq <= e_seq;
        out_node <= e_node;
        last <= e_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_r <= req_type;
            dest_r <= dest_node;
            src_r <= source_node;
            seq_r <= frame_seq;
            kind_r <= frame_kind;
            state <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          idx <= '0;
          case (req_r)
            art_pkg::REQ_SEND: begin
              if (dest_r == broadcast_node) begin
                if (proceed) begin
                  next_seq <= seq_inc;
                  ev2 <= art_pkg::EV_ACKED_OK;
                  seq2 <= next_seq;
                  node2 <= dest_r;
                  state <= ST_EMIT2;
                end
              end else if (full) begin
                if (proceed) begin
                  state <= ST_IDLE;
                end
              end else begin
                free_idx <= free_found;
                cur_seq <= next_seq;
                next_seq <= seq_inc;
                mode <= MODE_SEND;
                state <= ST_SC_RD;
              end
            end
            art_pkg::REQ_FRAME: begin
              if (want) begin
                if (proceed) begin
                  state <= ST_IDLE;
                end
              end else if (kind_r == art_pkg::KIND_ACK) begin
                cur_seq <= seq_r;
                mode <= MODE_ACK;
                state <= ST_SC_RD;
              end else begin
                state <= ST_FR_CHK;
              end
            end
            art_pkg::REQ_TICK: begin
              mode <= MODE_TICK;
              state <= ST_SC_RD;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_FR_CHK: begin
          if (proceed) begin
            if (!dup && src_ok) begin
              seen_source[src_r[art_pkg::NODE_IW-1:0]] <= 1'b1;
            end
            if (!dup && kind_r == art_pkg::KIND_DATA && dest_r != broadcast_node) begin
              ev2 <= art_pkg::EV_DELIVER;
              seq2 <= seq_r;
              node2 <= src_r;
              state <= ST_EMIT2;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_SC_RD: begin
          if (at_end) begin
            state <= ST_SC_END;
          end else if (slot_valid[idx_s]) begin
            state <= ST_SC_CHK;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_SC_CHK: begin
          if (proceed) begin
            idx <= idx + 1'b1;
            case (mode)
              MODE_SEND: begin
                if (hit) begin
                  state <= ST_IDLE;
                end else begin
                  state <= ST_SC_RD;
                end
              end
              MODE_ACK: begin
                if (hit) begin
                  slot_valid[idx_s] <= 1'b0;
                  state <= ST_IDLE;
                end else begin
                  state <= ST_SC_RD;
                end
              end
              default: begin
                if (timed && !can_retry) begin
                  slot_valid[idx_s] <= 1'b0;
                end
                state <= ST_SC_RD;
              end
            endcase
          end
        end
        ST_SC_END: begin
          if (proceed) begin
            if (mode == MODE_SEND) begin
              slot_valid[free_idx] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        ST_EMIT2: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/art_checker.sv -----
// port-level checker for the ack retransmit tracker, bound to the top level
`timescale 1ns / 1ps
`include "ack_retransmit_tracker_core_macros.svh"
module art_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] event_res,
  input logic [7:0] out_seq,
  input logic       last
);
  `ART_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ART_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)
  `ART_ASSERT_NOW(a_tick_last, clk, rst, out_valid && event_res == art_pkg::EV_TICK_DONE, last)
  `ART_ASSERT_NOW(a_rej_form, clk, rst, out_valid && event_res == art_pkg::EV_REJECTED, last && out_seq == 8'd0)
endmodule

bind ack_retransmit_tracker_core art_checker u_art_checker (.*);

// ----- tb/testbench.sv -----
// self-checking testbench for the ack retransmit tracker with a built-in tracker predictor
`timescale 1ns / 1ps
module testbench;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 100;

  typedef struct {
    logic [3:0] ev;
    logic [7:0] seq;
    logic [7:0] node;
    logic       fin;
  } event_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type = art_pkg::REQ_SEND;
  logic [7:0] dest_node = '0;
  logic [7:0] source_node = '0;
  logic [7:0] frame_seq = '0;
  logic [1:0] frame_kind = art_pkg::KIND_DATA;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] event_res;
  logic [7:0] out_seq;
  logic [7:0] out_node;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = art_pkg::CFG_OWN_NODE;
  logic [15:0] cfg_data = '0;

  ack_retransmit_tracker_core u_top (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // tracker state mirror
  logic [7:0]  m_own, m_bcast, m_seq_ctr;
  logic [15:0] m_timeout;
  logic [3:0]  m_retry;
  logic        m_pend_valid [art_pkg::PENDING_SLOTS];
  logic [7:0]  m_pend_seq [art_pkg::PENDING_SLOTS];
  logic [7:0]  m_pend_dest [art_pkg::PENDING_SLOTS];
  logic [3:0]  m_pend_retries [art_pkg::PENDING_SLOTS];
  logic [15:0] m_pend_age [art_pkg::PENDING_SLOTS];
  logic        m_seen [art_pkg::NODE_COUNT];
  logic [7:0]  m_last_seq [art_pkg::NODE_COUNT];

  event_word_t expected_events[$];
  int item_events;
  int fail_count = 0;
  int idle_cycles = 0;
  bit quiet = 0;
  int hold_cycles = 0;
  int stall_left = 0;

  function automatic void expect_event(logic [3:0] ev, logic [7:0] seq, logic [7:0] node);
    event_word_t w;
    w.ev = ev;
    w.seq = seq;
    w.node = node;
    w.fin = 1'b0;
    expected_events.push_back(w);
    item_events++;
  endfunction

  function automatic void bump_seq();
    m_seq_ctr = m_seq_ctr + 8'd1;
    if (m_seq_ctr == 8'd0) m_seq_ctr = 8'd1;
  endfunction

  function automatic void predict_send(logic [7:0] d);
    int free_idx;
    logic [7:0] sq;
    free_idx = -1;
    sq = m_seq_ctr;
    if (d == m_bcast) begin
      bump_seq();
      expect_event(art_pkg::EV_QUEUED, sq, d);
      expect_event(art_pkg::EV_ACKED_OK, sq, d);
      return;
    end
    for (int i = art_pkg::PENDING_SLOTS - 1; i >= 0; i--) if (!m_pend_valid[i]) free_idx = i;
    if (free_idx < 0) begin
      expect_event(art_pkg::EV_REJECTED, 8'd0, d);
      return;
    end
    bump_seq();
    for (int i = 0; i < art_pkg::PENDING_SLOTS; i++) begin
      if (m_pend_valid[i] && m_pend_seq[i] == sq) begin
        expect_event(art_pkg::EV_QUEUED, sq, d);
        return;
      end
    end
    m_pend_valid[free_idx] = 1'b1;
    m_pend_seq[free_idx] = sq;
    m_pend_dest[free_idx] = d;
    m_pend_retries[free_idx] = '0;
    m_pend_age[free_idx] = '0;
    expect_event(art_pkg::EV_QUEUED, sq, d);
  endfunction

  function automatic void predict_frame(logic [7:0] d, logic [7:0] s, logic [7:0] sq,
                                        logic [1:0] k);
    if (d != m_own && d != m_bcast) begin
      expect_event(art_pkg::EV_DROPPED, sq, s);
      return;
    end
    if (k == art_pkg::KIND_ACK) begin
      for (int i = 0; i < art_pkg::PENDING_SLOTS; i++) begin
        if (m_pend_valid[i] && m_pend_seq[i] == sq) begin
          m_pend_valid[i] = 1'b0;
          expect_event(art_pkg::EV_ACKED_OK, sq, m_pend_dest[i]);
          return;
        end
      end
      expect_event(art_pkg::EV_DROPPED, sq, s);
      return;
    end
    if (k != art_pkg::KIND_DATA && k != art_pkg::KIND_HB) begin
      expect_event(art_pkg::EV_DROPPED, sq, s);
      return;
    end
    if (m_seen[s] && m_last_seq[s] == sq) begin
      expect_event(art_pkg::EV_DROPPED, sq, s);
      return;
    end
    m_seen[s] = 1'b1;
    m_last_seq[s] = sq;
    if (k == art_pkg::KIND_DATA) begin
      if (d != m_bcast) expect_event(art_pkg::EV_ACK_OUT, sq, s);
      expect_event(art_pkg::EV_DELIVER, sq, s);
    end
  endfunction

  function automatic void predict_tick();
    for (int i = 0; i < art_pkg::PENDING_SLOTS; i++) begin
      if (!m_pend_valid[i]) continue;
      if (m_pend_age[i] != 16'hFFFF) m_pend_age[i] = m_pend_age[i] + 16'd1;
      if (m_pend_age[i] >= m_timeout) begin
        if (m_pend_retries[i] < m_retry) begin
          m_pend_retries[i] = m_pend_retries[i] + 4'd1;
          m_pend_age[i] = '0;
          expect_event(art_pkg::EV_RETRANSMIT, m_pend_seq[i], m_pend_dest[i]);
        end else begin
          m_pend_valid[i] = 1'b0;
          expect_event(art_pkg::EV_FAILED, m_pend_seq[i], m_pend_dest[i]);
        end
      end
    end
    expect_event(art_pkg::EV_TICK_DONE, 8'd0, 8'd0);
  endfunction

  function automatic void predict_word(logic [1:0] rq, logic [7:0] d, logic [7:0] s,
                                       logic [7:0] sq, logic [1:0] k);
    item_events = 0;
    case (rq)
      art_pkg::REQ_SEND: predict_send(d);
      art_pkg::REQ_FRAME: predict_frame(d, s, sq, k);
      art_pkg::REQ_TICK: predict_tick();
      default: ;
    endcase
    if (item_events > 0) expected_events[$].fin = 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    event_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected word: event_res %0d out_seq %0d out_node %0d",
               event_res, out_seq, out_node);
        fail_count++;
      end else begin
        w = expected_events.pop_front();
        if (event_res !== w.ev) begin
          $error("event_res expected %0d actual %0d", w.ev, event_res);
          fail_count++;
        end
        if (out_seq !== w.seq) begin
          $error("out_seq expected %0d actual %0d", w.seq, out_seq);
          fail_count++;
        end
        if (out_node !== w.node) begin
          $error("out_node expected %0d actual %0d", w.node, out_node);
          fail_count++;
        end
        if (last !== w.fin) begin
          $error("last expected %0d actual %0d", w.fin, last);
          fail_count++;
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver with random stalls and long hold-offs
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 8);
      end
    end
  end

  task automatic send_word(logic [1:0] rq, logic [7:0] d, logic [7:0] s, logic [7:0] sq,
                           logic [1:0] k);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = rq;
    dest_node = d;
    source_node = s;
    frame_seq = sq;
    frame_kind = k;
    do @(posedge clk); while (!in_ready);
    predict_word(rq, d, s, sq, k);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      art_pkg::CFG_OWN_NODE: m_own = val[7:0];
      art_pkg::CFG_BCAST: m_bcast = val[7:0];
      art_pkg::CFG_TIMEOUT: m_timeout = val;
      art_pkg::CFG_RETRY: m_retry = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic setup(logic [7:0] own, logic [7:0] bc, logic [15:0] tmo, logic [3:0] rl);
    write_reg(art_pkg::CFG_OWN_NODE, {8'd0, own});
    write_reg(art_pkg::CFG_BCAST, {8'd0, bc});
    write_reg(art_pkg::CFG_TIMEOUT, tmo);
    write_reg(art_pkg::CFG_RETRY, {12'd0, rl});
  endtask

  task automatic send_tick();
    send_word(art_pkg::REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
  endtask

  task automatic test_directed();
    send_word(art_pkg::REQ_SEND, 8'd255, 8'd0, 8'd0, art_pkg::KIND_DATA);
    send_word(art_pkg::REQ_SEND, 8'd0, 8'd255, 8'd255, art_pkg::KIND_HB);
    send_word(art_pkg::REQ_SEND, 8'd7, 8'd1, 8'd1, art_pkg::KIND_DATA);
    send_word(art_pkg::REQ_FRAME, 8'd0, 8'd7, 8'd2, art_pkg::KIND_ACK);
    send_word(art_pkg::REQ_FRAME, 8'd255, 8'd7, 8'd2, art_pkg::KIND_ACK);
    send_word(art_pkg::REQ_FRAME, 8'd9, 8'd5, 8'd3, art_pkg::KIND_DATA);
    send_word(art_pkg::REQ_FRAME, 8'd0, 8'd5, 8'd3, art_pkg::KIND_DATA);
    send_word(art_pkg::REQ_FRAME, 8'd0, 8'd5, 8'd3, art_pkg::KIND_DATA);
    send_word(art_pkg::REQ_FRAME, 8'd255, 8'd255, 8'd0, art_pkg::KIND_DATA);
    send_word(art_pkg::REQ_FRAME, 8'd0, 8'd6, 8'd255, art_pkg::KIND_HB);
    send_word(art_pkg::REQ_FRAME, 8'd0, 8'd6, 8'd255, art_pkg::KIND_HB);
    send_word(art_pkg::REQ_FRAME, 8'd0, 8'd0, 8'd4, 2'd3);
    send_word(art_pkg::REQ_TICK, 8'd0, 8'd0, 8'd0, art_pkg::KIND_DATA);
    send_word(2'd3, 8'd255, 8'd255, 8'd255, 2'd3);
    send_word(art_pkg::REQ_TICK, 8'd255, 8'd255, 8'd255, 2'd3);
  endtask

  task automatic test_timeout();
    setup(8'd255, 8'd0, 16'd1, 4'd0);
    send_word(art_pkg::REQ_SEND, 8'd3, 8'd0, 8'd0, art_pkg::KIND_DATA);
    send_tick();
    setup(8'd255, 8'd0, 16'd2, 4'd2);
    send_word(art_pkg::REQ_SEND, 8'd4, 8'd0, 8'd0, art_pkg::KIND_DATA);
    send_word(art_pkg::REQ_SEND, 8'd255, 8'd0, 8'd0, art_pkg::KIND_DATA);
    repeat (7) send_tick();
  endtask

  task automatic test_table_full();
    setup(8'd0, 8'd255, 16'd65535, 4'd15);
    repeat (art_pkg::PENDING_SLOTS + 2)
      send_word(art_pkg::REQ_SEND, 8'($urandom_range(0, 254)), 8'd0, 8'd0, art_pkg::KIND_DATA);
    send_tick();
    // free one slot and keep the rest pending
    send_word(art_pkg::REQ_FRAME, 8'd0, 8'd1, m_pend_seq[0], art_pkg::KIND_ACK);
    // wrap the sequence onto an entry still pending
    while (m_seq_ctr != m_pend_seq[5])
      send_word(art_pkg::REQ_SEND, 8'd255, 8'd0, 8'd0, art_pkg::KIND_DATA);
    send_word(art_pkg::REQ_SEND, 8'd9, 8'd0, 8'd0, art_pkg::KIND_DATA);
    send_word(art_pkg::REQ_FRAME, 8'd255, 8'd2, m_pend_seq[5], art_pkg::KIND_ACK);
    send_word(art_pkg::REQ_FRAME, 8'd0, 8'd2, m_pend_seq[5], art_pkg::KIND_ACK);
  endtask

  task automatic random_word();
    int r;
    int picks[$];
    logic [7:0] d, s, sq;
    logic [1:0] k;
    r = $urandom_range(0, 99);
    d = 8'($urandom);
    s = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    sq = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    k = 2'($urandom_range(0, 3));
    if (r < 30) begin
      if ($urandom_range(0, 4) == 0) d = m_bcast;
      else if ($urandom_range(0, 1) == 0) d = 8'($urandom_range(1, 8));
      send_word(art_pkg::REQ_SEND, d, s, sq, k);
    end else if (r < 68) begin
      if ($urandom_range(0, 9) < 7) d = m_own;
      else if ($urandom_range(0, 1) == 0) d = m_bcast;
      r = $urandom_range(0, 19);
      k = (r < 8) ? art_pkg::KIND_ACK : (r < 15) ? art_pkg::KIND_DATA :
          (r < 19) ? art_pkg::KIND_HB : 2'd3;
      if (k == art_pkg::KIND_ACK) begin
        for (int i = 0; i < art_pkg::PENDING_SLOTS; i++) if (m_pend_valid[i]) picks.push_back(i);
        if (picks.size() > 0 && $urandom_range(0, 4) != 0)
          sq = m_pend_seq[picks[$urandom_range(0, picks.size() - 1)]];
      end
      send_word(art_pkg::REQ_FRAME, d, s, sq, k);
    end else if (r < 96) begin
      send_word(art_pkg::REQ_TICK, d, s, sq, k);
    end else begin
      send_word(2'd3, d, s, sq, k);
    end
  endtask

  task automatic test_random();
    setup(8'd0, 8'd255, 16'd3, 4'd2);
    repeat (15) random_word();
    setup(8'd255, 8'd255, 16'd1, 4'd0);
    repeat (12) random_word();
    setup(8'($urandom_range(0, 8)), 8'd0, 16'd65535, 4'd15);
    repeat (12) random_word();
    setup(8'($urandom), 8'($urandom), 16'($urandom_range(1, 5)), 4'($urandom));
    repeat (12) random_word();
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_cycles = 300;
    repeat (12) random_word();
    drain();
    repeat (6) random_word();
  endtask

  task automatic test_quiet_tail();
    drain();
    quiet = 1;
    repeat (16) random_word();
  endtask

  initial begin
    m_own = 8'd0;
    m_bcast = 8'd255;
    m_timeout = 16'd10;
    m_retry = 4'd3;
    m_seq_ctr = 8'd1;
    for (int i = 0; i < art_pkg::PENDING_SLOTS; i++) m_pend_valid[i] = 1'b0;
    for (int i = 0; i < art_pkg::NODE_COUNT; i++) m_seen[i] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_timeout();
    test_table_full();
    test_random();
    test_backpressure();
    test_quiet_tail();
    drain();
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
